>>> sv/asub_pkg.sv
// Shared types and constants for the aging subscriber table.
// No dependencies; every other file imports this package.
package asub_pkg;

  localparam int TIME_W      = 48;
  localparam int IP_W        = 32;
  localparam int PORT_W      = 16;
  localparam int SLOT_W      = 2;
  localparam int CNT_W       = 3;
  localparam int MAX_RESULTS = 4;
  localparam int SLOTS_DEF   = 4;

  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(5000000);

  typedef enum logic {
    OP_SUB = 1'b0,
    OP_PUB = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_REFRESHED = 2'd0,
    ST_ADDED     = 2'd1,
    ST_DROPPED   = 2'd2,
    ST_DEST      = 2'd3
  } status_t;

  // Request travelling down the row of cells.
  typedef struct packed {
    op_t                op;
    logic [TIME_W-1:0]  now;
    logic [IP_W-1:0]    ip;
    logic [PORT_W-1:0]  port;
    logic [TIME_W-1:0]  expires;
    logic               hit;
    logic               free;
    logic               pend_valid;
    logic [SLOT_W-1:0]  pend_slot;
    logic [IP_W-1:0]    pend_ip;
    logic [PORT_W-1:0]  pend_port;
    logic [CNT_W-1:0]   cnt;
  } tok_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [IP_W-1:0]    dest_ip;
    logic [PORT_W-1:0]  dest_port;
    logic               last;
  } res_t;

  // Entry write broadcast to the cells.
  typedef struct packed {
    logic               en;
    logic [IP_W-1:0]    ip;
    logic [PORT_W-1:0]  port;
    logic [TIME_W-1:0]  expiry;
  } wr_t;

endpackage

>>> sv/asub_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on asub_pkg for field widths.
interface asub_in_if import asub_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] now_us;
  logic [IP_W-1:0]   peer_ip;
  logic [PORT_W-1:0] peer_port;

  modport source (output valid, operation, now_us, peer_ip, peer_port, input ready);
  modport sink   (input valid, operation, now_us, peer_ip, peer_port, output ready);
endinterface

interface asub_out_if import asub_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot;
  logic [IP_W-1:0]   dest_ip;
  logic [PORT_W-1:0] dest_port;
  logic              last;

  modport source (output valid, status, slot, dest_ip, dest_port, last, input ready);
  modport sink   (input valid, status, slot, dest_ip, dest_port, last, output ready);
endinterface

>>> sv/asub_cell.sv
// One table slot: holds an entry and evaluates the passing request against it.
// Depends on asub_pkg.
module asub_cell import asub_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX   = 0,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tok_t             tok_in,
  input  logic [IDX_W-1:0] hit_idx_in,
  input  logic [IDX_W-1:0] free_idx_in,
  input  logic             out_free,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] wr_idx,
  output logic             occ,
  output logic             pass,
  output tok_t             tok_nxt,
  output logic [IDX_W-1:0] hit_idx_nxt,
  output logic [IDX_W-1:0] free_idx_nxt,
  output logic             push,
  output res_t             res
);

  localparam logic [IDX_W-1:0] OWN = IDX_W'(IDX);

  tok_t              tok;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IP_W-1:0]   ent_ip;
  logic [PORT_W-1:0] ent_port;
  logic [TIME_W-1:0] ent_exp;
  logic              live;
  logic              take;
  logic              need;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= 1'b0;
      ent_ip   <= '0;
      ent_port <= '0;
      ent_exp  <= '0;
    end else begin
      if (load) begin
        occ <= 1'b1;
      end else if (pass) begin
        occ <= 1'b0;
      end
      if (wr.en && wr_idx == OWN) begin
        ent_ip   <= wr.ip;
        ent_port <= wr.port;
        ent_exp  <= wr.expiry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok      <= tok_in;
      hit_idx  <= hit_idx_in;
      free_idx <= free_idx_in;
    end
  end

  always_comb begin
    live         = ent_exp > tok.now;
    take         = (tok.op == OP_PUB) && live && (tok.cnt < CNT_W'(MAX_RESULTS));
    need         = occ && take && tok.pend_valid;
    push         = need && out_free;
    pass         = occ && (!need || out_free);
    tok_nxt      = tok;
    hit_idx_nxt  = hit_idx;
    free_idx_nxt = free_idx;
    res          = '0;
    if (need) begin
      res.status    = ST_DEST;
      res.slot      = tok.pend_slot;
      res.dest_ip   = tok.pend_ip;
      res.dest_port = tok.pend_port;
      res.last      = 1'b0;
    end
    if (tok.op == OP_PUB) begin
      if (take) begin
        tok_nxt.pend_valid = 1'b1;
        tok_nxt.pend_slot  = SLOT_W'(IDX);
        tok_nxt.pend_ip    = ent_ip;
        tok_nxt.pend_port  = ent_port;
        tok_nxt.cnt        = tok.cnt + CNT_W'(1);
      end
    end else begin
      if (!tok.hit && live && ent_ip == tok.ip && ent_port == tok.port) begin
        tok_nxt.hit = 1'b1;
        hit_idx_nxt = OWN;
      end
      if (!live && !tok.free) begin
        tok_nxt.free = 1'b1;
        free_idx_nxt = OWN;
      end
    end
  end

endmodule

>>> sv/aging_subscriber_table.sv
// Top level of the aging subscriber table: row of slot cells, finish stage,
// result register and TTL register. Depends on asub_pkg, asub_if, asub_cell.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   operation, now_us, peer_ip, peer_port
//   out_ch   out  valid/ready   status, slot, dest_ip, dest_port, last
//   cfg      in   cfg_wr_en     cfg_wr_data (ttl_us)
//
// A request walks the row one cell per cycle while the result register has room,
// then a finish stage. One item is in flight at a time: the block takes no new
// transfer until the finish stage is done with the last one.
// A stalled result register holds the request in its cell until it drains.
// Reset clears all slots at once; there is no clearing pass.
module aging_subscriber_table import asub_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  asub_in_if.sink           in_ch,
  asub_out_if.source        out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TIME_W-1:0] ttl;
  logic              busy;
  logic              accept;
  logic [TIME_W:0]   sum;
  tok_t              new_tok;

  tok_t              tok_c      [0:SLOTS];
  logic              load_c     [0:SLOTS];
  logic [IDX_W-1:0]  hit_c      [0:SLOTS];
  logic [IDX_W-1:0]  free_c     [0:SLOTS];
  logic [SLOTS-1:0]  push_c;
  logic [SLOTS-1:0]  occ_c;
  res_t              res_c      [0:SLOTS-1];

  logic              fin_occ;
  tok_t              fin_tok;
  logic [IDX_W-1:0]  fin_hit_idx;
  logic [IDX_W-1:0]  fin_free_idx;
  logic              fin_need;
  logic              fin_push;
  logic              fin_done;
  res_t              fin_res;
  wr_t               wr;
  logic [IDX_W-1:0]  wr_idx;

  logic              cell_push;
  res_t              cell_res;
  logic              out_free;
  logic              push;
  logic              out_valid;
  res_t              out_res;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy;
  assign out_free    = !out_valid || out_ch.ready;

  always_comb begin
    sum                = {1'b0, in_ch.now_us} + {1'b0, ttl};
    new_tok            = '0;
    new_tok.op         = op_t'(in_ch.operation);
    new_tok.now        = in_ch.now_us;
    new_tok.ip         = in_ch.peer_ip;
    new_tok.port       = in_ch.peer_port;
    new_tok.expires    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  end

  assign tok_c[0]  = new_tok;
  assign load_c[0] = accept;
  assign hit_c[0]  = '0;
  assign free_c[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    asub_cell #(.SLOTS(SLOTS), .IDX(i)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .load         (load_c[i]),
      .tok_in       (tok_c[i]),
      .hit_idx_in   (hit_c[i]),
      .free_idx_in  (free_c[i]),
      .out_free     (out_free),
      .wr           (wr),
      .wr_idx       (wr_idx),
      .occ          (occ_c[i]),
      .pass         (load_c[i+1]),
      .tok_nxt      (tok_c[i+1]),
      .hit_idx_nxt  (hit_c[i+1]),
      .free_idx_nxt (free_c[i+1]),
      .push         (push_c[i]),
      .res          (res_c[i])
    );
  end

  always_comb begin
    cell_push = |push_c;
    cell_res  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cell_res = cell_res | res_c[i];
    end
  end

  // Finish stage: decide the subscribe outcome or flush the held destination.
  always_comb begin
    fin_need = fin_occ && (fin_tok.op == OP_SUB || fin_tok.pend_valid);
    fin_push = fin_need && out_free;
    fin_done = fin_occ && (!fin_need || out_free);
    fin_res  = '0;
    wr       = '0;
    wr_idx   = '0;
    fin_res.last = 1'b1;
    if (fin_tok.op == OP_PUB) begin
      fin_res.status    = ST_DEST;
      fin_res.slot      = fin_tok.pend_slot;
      fin_res.dest_ip   = fin_tok.pend_ip;
      fin_res.dest_port = fin_tok.pend_port;
    end else begin
      wr.ip     = fin_tok.ip;
      wr.port   = fin_tok.port;
      wr.expiry = fin_tok.expires;
      if (fin_tok.hit) begin
        fin_res.status = ST_REFRESHED;
        fin_res.slot   = SLOT_W'(fin_hit_idx);
        wr_idx         = fin_hit_idx;
        wr.en          = fin_done;
      end else if (fin_tok.free) begin
        fin_res.status = ST_ADDED;
        fin_res.slot   = SLOT_W'(fin_free_idx);
        wr_idx         = fin_free_idx;
        wr.en          = fin_done;
      end else begin
        fin_res.status = ST_DROPPED;
      end
    end
  end

  assign push = cell_push || fin_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl       <= TTL_RESET;
      busy      <= 1'b0;
      fin_occ   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ttl <= cfg_wr_data;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (fin_done) begin
        busy <= 1'b0;
      end
      if (load_c[SLOTS]) begin
        fin_occ <= 1'b1;
      end else if (fin_done) begin
        fin_occ <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_c[SLOTS]) begin
      fin_tok      <= tok_c[SLOTS];
      fin_hit_idx  <= hit_c[SLOTS];
      fin_free_idx <= free_c[SLOTS];
    end
    if (push) begin
      out_res <= fin_push ? fin_res : cell_res;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_res.status;
  assign out_ch.slot      = out_res.slot;
  assign out_ch.dest_ip   = out_res.dest_ip;
  assign out_ch.dest_port = out_res.dest_port;
  assign out_ch.last      = out_res.last;

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    $onehot0({occ_c, fin_occ}))
    else $error("more than one request in flight");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    accept |-> (occ_c == '0) && !fin_occ)
    else $error("transfer taken while a request is in flight");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free && !(cell_push && fin_push))
    else $error("result pushed into a full register");

  a_write_finish: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> fin_occ && fin_tok.op == OP_SUB)
    else $error("slot written outside a subscribe finish");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    fin_done |=> !busy)
    else $error("block still busy after a request finished");

endmodule

>>> sim/subscriber_table_checker.sv
// Result checker for the aging subscriber table: watches both channels, predicts
// the results of every input transfer from its own copy of the table and compares.
// Depends on asub_pkg and the channel interfaces in asub_if.
module subscriber_table_checker import asub_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  asub_in_if                in_ch,
  asub_out_if               out_ch,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam int                REPORT_MAX = 10;

  logic [TIME_W-1:0] ttl_cur;
  logic [IP_W-1:0]   sub_ip     [SLOTS_DEF];
  logic [PORT_W-1:0] sub_port   [SLOTS_DEF];
  logic [TIME_W-1:0] sub_expiry [SLOTS_DEF];
  res_t              due_results[$];
  int                fail_count  = 0;
  int                outstanding = 0;

  assign fails   = fail_count;
  assign pending = outstanding;

  task automatic table_request(input op_t op, input logic [TIME_W-1:0] now,
                               input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] expires;
    int                free_idx;
    int                hit_idx;
    res_t              r;
    res_t              fanout[$];
    sum      = {1'b0, now} + {1'b0, ttl_cur};
    expires  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    free_idx = -1;
    hit_idx  = -1;
    r        = '0;
    if (op == OP_SUB) begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (hit_idx < 0) begin
          if (sub_expiry[i] > now && sub_ip[i] == ip && sub_port[i] == port) begin
            hit_idx = i;
          end else if (sub_expiry[i] <= now && free_idx < 0) begin
            free_idx = i;
          end
        end
      end
      r.last = 1'b1;
      if (hit_idx >= 0) begin
        sub_expiry[hit_idx] = expires;
        r.status = ST_REFRESHED;
        r.slot   = SLOT_W'(hit_idx);
      end else if (free_idx >= 0) begin
        sub_ip[free_idx]     = ip;
        sub_port[free_idx]   = port;
        sub_expiry[free_idx] = expires;
        r.status = ST_ADDED;
        r.slot   = SLOT_W'(free_idx);
      end else begin
        r.status = ST_DROPPED;
      end
      due_results.push_back(r);
    end else begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (sub_expiry[i] > now && fanout.size() < MAX_RESULTS) begin
          r.status    = ST_DEST;
          r.slot      = SLOT_W'(i);
          r.dest_ip   = sub_ip[i];
          r.dest_port = sub_port[i];
          r.last      = 1'b0;
          fanout.push_back(r);
        end
      end
      if (fanout.size() > 0) fanout[fanout.size()-1].last = 1'b1;
      foreach (fanout[k]) due_results.push_back(fanout[k]);
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    bit   bad;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0t: unexpected result status=%0d slot=%0d ip=%h port=%h last=%0d",
                 $time, got.status, got.slot, got.dest_ip, got.dest_port, got.last);
    end else begin
      want = due_results.pop_front();
      bad  = (got.status !== want.status) || (got.slot !== want.slot) ||
             (got.dest_ip !== want.dest_ip) || (got.dest_port !== want.dest_port) ||
             (got.last !== want.last);
      if (bad) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("%0t: result mismatch", $time);
          $display("  expected status=%0d slot=%0d ip=%h port=%h last=%0d",
                   want.status, want.slot, want.dest_ip, want.dest_port, want.last);
          $display("  actual   status=%0d slot=%0d ip=%h port=%h last=%0d",
                   got.status, got.slot, got.dest_ip, got.dest_port, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ttl_cur = TTL_RESET;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        sub_ip[i]     = '0;
        sub_port[i]   = '0;
        sub_expiry[i] = '0;
      end
      due_results.delete();
    end else begin
      if (cfg_wr_en) ttl_cur = cfg_wr_data;
      if (out_ch.valid && out_ch.ready)
        check_result(res_t'({status_t'(out_ch.status), out_ch.slot, out_ch.dest_ip,
                             out_ch.dest_port, out_ch.last}));
      if (in_ch.valid && in_ch.ready)
        table_request(op_t'(in_ch.operation), in_ch.now_us, in_ch.peer_ip, in_ch.peer_port);
    end
    outstanding = due_results.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the aging subscriber table: clock, reset, lifetime writes,
// directed and random requests, receiver stalls and the verdict.
// Depends on asub_pkg, asub_if, aging_subscriber_table and subscriber_table_checker.
module tb import asub_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                HOLD_CYCLES = 400;
  localparam int                QUIET_LIMIT = 4000;
  localparam int                SETTLE      = SLOTS_DEF + 4;
  localparam int                POOL        = 6;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;
  int                fails;
  int                pending;
  int                idle_pct    = 0;
  int                stall_pct   = 0;
  int                hold_orders = 0;
  int                hold_seen   = 0;
  int                hold_left   = 0;
  int                quiet       = 0;
  logic [IP_W-1:0]   pool_ip   [POOL];
  logic [PORT_W-1:0] pool_port [POOL];

  asub_in_if  in_ch();
  asub_out_if out_ch();

  aging_subscriber_table u_top (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_ch, .out_ch
  );

  subscriber_table_checker u_checker (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_ch, .out_ch, .fails, .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_orders) begin
      hold_seen = hold_orders;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input logic [TIME_W-1:0] now,
                           input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.now_us    <= now;
    in_ch.peer_ip   <= ip;
    in_ch.peer_port <= port;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [TIME_W-1:0] ttl);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ttl;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] ttl, input int src_idle,
                           input int snk_stall, input int n_items, input bit squeeze);
    longint unsigned   now;
    longint unsigned   step_max;
    longint unsigned   adv;
    int                pick;
    op_t               op;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    drain();
    write_ttl(ttl);
    idle_pct  = src_idle;
    stall_pct = snk_stall;
    for (int k = 0; k < POOL; k++) begin
      pool_ip[k]   = $urandom;
      pool_port[k] = PORT_W'($urandom);
    end
    now      = 64'(TIME_W'({$urandom, $urandom}));
    step_max = ttl / 3;
    if (step_max < 2) step_max = 2;
    if (step_max > 64'd1000000) step_max = 64'd1000000;
    // hold the receiver off while requests keep coming
    if (squeeze) hold_orders++;
    for (int n = 0; n < n_items; n++) begin
      adv  = $urandom_range(32'(step_max));
      now  = (now + adv > TIME_MAX) ? 64'(TIME_MAX) : now + adv;
      pick = $urandom_range(POOL - 1);
      ip   = pool_ip[pick];
      port = pool_port[pick];
      op   = ($urandom_range(99) < 45) ? OP_SUB : OP_PUB;
      case ($urandom_range(9))
        0: begin
          ip   = $urandom;
          port = PORT_W'($urandom);
        end
        1: port = PORT_W'($urandom);
        default: ;
      endcase
      send_item(op, TIME_W'(now), ip, port);
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_SUB;
    in_ch.now_us    <= '0;
    in_ch.peer_ip   <= '0;
    in_ch.peer_port <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_PUB, 48'd0, 32'h0000_0000, 16'h0000);
    send_item(OP_SUB, 48'd0, 32'h0A00_0001, 16'd5683);
    send_item(OP_SUB, 48'd10, 32'h0A00_0001, 16'd5683);
    send_item(OP_SUB, 48'd20, 32'h0A00_0001, 16'd5684);
    send_item(OP_SUB, 48'd20, 32'h0000_0000, 16'h0000);
    send_item(OP_SUB, 48'd30, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_SUB, 48'd30, 32'hC0A8_0102, 16'd1);
    send_item(OP_PUB, 48'd40, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_SUB, 48'd5000015, 32'hC0A8_0102, 16'd1);
    send_item(OP_PUB, 48'd5000015, 32'h0000_0000, 16'h0000);
    send_item(OP_PUB, 48'd5000030, 32'h0000_0000, 16'h0000);
    send_item(OP_SUB, TIME_MAX, 32'h1234_5678, 16'h8000);
    send_item(OP_PUB, TIME_MAX, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_PUB, 48'd100, 32'h0000_0000, 16'h0000);
    send_item(OP_SUB, 48'd100, 32'h1234_5678, 16'h8000);
    send_item(OP_SUB, 48'h7FFF_FFFF_FFFF, 32'h5555_5555, 16'h5555);
    send_item(OP_PUB, 48'h7FFF_FFFF_FFFF, 32'hAAAA_AAAA, 16'hAAAA);
    send_item(OP_SUB, 48'h8000_0000_0000, 32'h5555_5555, 16'h5555);

    run_phase(48'd1, 88, 0, 60, 1'b0);
    run_phase(48'd200, 0, 88, 80, 1'b1);
    run_phase(TIME_MAX, 21, 21, 60, 1'b0);
    run_phase(48'd0, 0, 0, 40, 1'b0);
    run_phase(48'd37, 21, 21, 80, 1'b0);
    run_phase(TTL_RESET, 0, 0, 80, 1'b0);

    drain();
    @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
